/* hdl/pfba_pkg.sv */
`timescale 1ns / 1ps

package pfba_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int OFS_W       = $clog2(PAGE_BYTES);
  localparam int CS_W        = OFS_W + 1;
  localparam int HDR_W       = 32;
  localparam int SIZE_W      = 16;
  localparam int LEN_W       = SIZE_W + 2;
  localparam int FRAG_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int FRAG_CUTOFF = 3;
  localparam int MIN_BLOCK   = 4;
  localparam int MAX_HOPS    = PAGE_BYTES / 4 + 1;
  localparam int HOP_W       = $clog2(MAX_HOPS + 1);
  localparam int GAP_W       = 2;
  localparam int DIFF_W      = 3;
  localparam int MAX_FRAG_RESET = 255;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_FLOOR     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAGMENTS = CFG_IDX_W'(1);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_CORRUPT  = 2'd2,
    ST_DEFRAG   = 2'd3
  } status_t;

endpackage

/* hdl/pfba_if.sv */
`timescale 1ns / 1ps

interface pfba_req_if import pfba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [OFS_W-1:0] alloc_size;
  logic [OFS_W-1:0] block_offset;
  logic [OFS_W-1:0] block_length;

  modport source (output valid, func, alloc_size, block_offset, block_length, input ready);
  modport sink   (input valid, func, alloc_size, block_offset, block_length, output ready);
endinterface

interface pfba_rsp_if import pfba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFS_W-1:0]    offset;
  logic [STATUS_W-1:0] status;

  modport source (output valid, offset, status, input ready);
  modport sink   (input valid, offset, status, output ready);
endinterface

interface pfba_cfg_if import pfba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/pfba_ram.sv */
`timescale 1ns / 1ps

module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/page_free_block_allocator_unit.sv */
`timescale 1ns / 1ps
// Channel  Dir  Payload                                         Transfer
// req      in   func, alloc_size, block_offset, block_length    req.valid & req.ready
// rsp      out  offset, status                                  rsp.valid & rsp.ready
// cfg      in   index, data (0 gap_floor, 1 max_fragments)      cfg.valid & cfg.ready
//
// Allocate from the gap answers from S_A_START; a list allocate walks the free
// list first. A release refused at once or under 4 bytes answers from S_R_START,
// else it may walk the list, then checks both neighbours and writes headers; one
// list hop per cycle, set by the header memory's single registered read port.
// Reset (synchronous): empty free list, cell_top at page size, no fragments.
// A stalled rsp holds the result register; one more request is taken and its
// result waits until the register frees up.

module page_free_block_allocator_unit import pfba_pkg::*; (
  input logic          clk,
  input logic          rst,
  pfba_req_if.sink     req,
  pfba_rsp_if.source   rsp,
  pfba_cfg_if.sink     cfg
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_START,
    S_A_HOP,
    S_R_START,
    S_R_WALK,
    S_R_PREV,
    S_R_NEXT,
    S_R_WRITE,
    S_R_LINK,
    S_RESP
  } state_t;

  state_t state, state_next;

  // control state
  logic [OFS_W-1:0]  free_head, free_head_next;
  logic [CS_W-1:0]   cell_top, cell_top_next;
  logic [FRAG_W-1:0] frag, frag_next;
  logic [OFS_W-1:0]  gap_floor;
  logic [FRAG_W-1:0] max_frag;
  logic              out_valid, out_valid_next;
  logic [HOP_W-1:0]  hops, hops_next;

  // working payload
  logic [OFS_W-1:0]  need, need_next;
  logic [OFS_W-1:0]  ofs, ofs_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [OFS_W-1:0]  cur, cur_next;
  logic [OFS_W-1:0]  prev, prev_next;
  logic [SIZE_W-1:0] prev_size, prev_size_next;
  logic [OFS_W-1:0]  head, head_next;
  logic              link_prev, link_prev_next;
  logic [DIFF_W-1:0] merge_slack, merge_slack_next;
  logic [OFS_W-1:0]  res_offset, res_offset_next;
  status_t           res_status, res_status_next;
  logic [OFS_W-1:0]  out_offset, out_offset_next;
  status_t           out_status, out_status_next;

  // header memory
  logic              rd_en, wr_en;
  logic [OFS_W-1:0]  rd_addr, wr_addr;
  logic [HDR_W-1:0]  rd_data, wr_data;

  pfba_ram #(
    .WIDTH (HDR_W),
    .DEPTH (PAGE_BYTES)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // header fields and datapath terms
  logic [SIZE_W-1:0] rd_size;
  logic [SIZE_W-1:0] rd_link;
  logic [OFS_W-1:0]  rd_ptr;
  logic [CS_W-1:0]   gap;
  logic              frag_guard;
  logic [HOP_W-1:0]  hops_inc;
  logic              hop_ok;
  logic              fit;
  logic [SIZE_W-1:0] left;
  logic [LEN_W-1:0]  blk_end;
  logic              rel_bad;
  logic              small_over;
  logic [LEN_W-1:0]  pend;
  logic              prev_bad, prev_merge;
  logic [GAP_W-1:0]  prev_gap;
  logic [OFS_W-1:0]  m_ofs;
  logic [LEN_W-1:0]  m_len;
  logic              next_bad, next_merge;
  logic [GAP_W-1:0]  next_gap;
  logic [FRAG_W-1:0] frag_sub;
  logic              in_xfer;

  assign rd_size    = rd_data[HDR_W-1:SIZE_W];
  assign rd_link    = rd_data[SIZE_W-1:0];
  assign rd_ptr     = rd_link[OFS_W-1:0];
  assign gap        = (cell_top >= CS_W'(gap_floor)) ? cell_top - CS_W'(gap_floor) : '0;
  assign frag_guard = ((FRAG_W+1)'(frag) + (FRAG_W+1)'(MIN_BLOCK - 1)) > (FRAG_W+1)'(max_frag);
  assign hops_inc   = hops + 1'b1;
  assign hop_ok     = hops_inc < HOP_W'(MAX_HOPS);
  assign fit        = SIZE_W'(need) <= rd_size;
  assign left       = rd_size - SIZE_W'(need);
  assign blk_end    = LEN_W'(ofs) + len;
  assign rel_bad    = (ofs == '0) || (CS_W'(ofs) < cell_top) ||
                      (blk_end > LEN_W'(PAGE_BYTES));
  assign small_over = (LEN_W'(frag) + len) > LEN_W'(max_frag);
  assign pend       = LEN_W'(prev) + LEN_W'(prev_size);
  assign prev_bad   = (prev != '0) && (pend > LEN_W'(ofs));
  assign prev_merge = (prev != '0) && (pend + LEN_W'(FRAG_CUTOFF) >= LEN_W'(ofs));
  assign prev_gap   = GAP_W'(LEN_W'(ofs) - pend);
  assign m_ofs      = prev_merge ? prev : ofs;
  assign m_len      = prev_merge ? len + LEN_W'(prev_size) + LEN_W'(prev_gap) : len;
  assign next_bad   = blk_end > LEN_W'(cur);
  assign next_merge = blk_end + LEN_W'(FRAG_CUTOFF) >= LEN_W'(cur);
  assign next_gap   = GAP_W'(LEN_W'(cur) - blk_end);
  assign frag_sub   = (frag >= FRAG_W'(merge_slack)) ? frag - FRAG_W'(merge_slack) : '0;

  assign in_xfer    = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.offset = out_offset;
  assign rsp.status = out_status;

  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    cell_top_next    = cell_top;
    frag_next        = frag;
    hops_next        = hops;
    need_next        = need;
    ofs_next         = ofs;
    len_next         = len;
    cur_next         = cur;
    prev_next        = prev;
    prev_size_next   = prev_size;
    head_next        = head;
    link_prev_next   = link_prev;
    merge_slack_next = merge_slack;
    res_offset_next  = res_offset;
    res_status_next  = res_status;
    out_offset_next  = out_offset;
    out_status_next  = out_status;
    out_valid_next   = out_valid && !rsp.ready;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          need_next  = req.alloc_size;
          ofs_next   = req.block_offset;
          len_next   = LEN_W'(req.block_length);
          res_offset_next = '0;
          state_next = (req.func == FUNC_ALLOC) ? S_A_START : S_R_START;
        end
      end

      S_A_START: begin
        state_next = S_RESP;
        if (frag_guard) begin
          res_status_next = ST_DEFRAG;
        end else if (gap >= CS_W'(need)) begin
          cell_top_next   = cell_top - CS_W'(need);
          res_offset_next = cell_top_next[OFS_W-1:0];
          res_status_next = ST_OK;
        end else if (free_head == '0) begin
          res_status_next = ST_NO_SPACE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = free_head;
          cur_next   = free_head;
          prev_next  = '0;
          hops_next  = '0;
          state_next = S_A_HOP;
        end
      end

      S_A_HOP: begin
        if (fit) begin
          if (left < SIZE_W'(MIN_BLOCK)) begin
            // leftover too small to keep: unlink block, count the bytes
            frag_next = frag + FRAG_W'(left);
            if (prev == '0) begin
              free_head_next = rd_ptr;
            end else begin
              wr_en   = 1'b1;
              wr_addr = prev;
              wr_data = {prev_size, rd_link};
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = cur;
            wr_data = {left, rd_link};
          end
          res_offset_next = cur + left[OFS_W-1:0];
          res_status_next = ST_OK;
          state_next      = S_RESP;
        end else begin
          prev_next      = cur;
          prev_size_next = rd_size;
          cur_next       = rd_ptr;
          hops_next      = hops_inc;
          if ((rd_ptr != '0) && hop_ok) begin
            rd_en   = 1'b1;
            rd_addr = rd_ptr;
          end else begin
            res_status_next = ST_NO_SPACE;
            state_next      = S_RESP;
          end
        end
      end

      S_R_START: begin
        prev_next        = '0;
        cur_next         = free_head;
        hops_next        = '0;
        merge_slack_next = '0;
        if (rel_bad) begin
          res_status_next = ST_CORRUPT;
          state_next      = S_RESP;
        end else if (len < LEN_W'(MIN_BLOCK)) begin
          if (small_over) begin
            res_status_next = ST_DEFRAG;
          end else begin
            frag_next       = frag + len[FRAG_W-1:0];
            res_status_next = ST_OK;
          end
          state_next = S_RESP;
        end else if ((free_head != '0) && (free_head < ofs)) begin
          rd_en      = 1'b1;
          rd_addr    = free_head;
          state_next = S_R_WALK;
        end else begin
          state_next = S_R_PREV;
        end
      end

      S_R_WALK: begin
        prev_next      = cur;
        prev_size_next = rd_size;
        cur_next       = rd_ptr;
        hops_next      = hops_inc;
        if ((rd_ptr != '0) && (rd_ptr < ofs) && hop_ok) begin
          rd_en   = 1'b1;
          rd_addr = rd_ptr;
        end else begin
          state_next = S_R_PREV;
        end
      end

      S_R_PREV: begin
        if (prev_bad) begin
          res_status_next = ST_CORRUPT;
          state_next      = S_RESP;
        end else begin
          ofs_next         = m_ofs;
          len_next         = m_len;
          merge_slack_next = prev_merge ? DIFF_W'(prev_gap) : '0;
          link_prev_next   = (m_ofs != prev) && (prev != '0);
          head_next        = ((m_ofs != prev) && (prev == '0)) ? m_ofs : free_head;
          if (cur != '0) begin
            rd_en      = 1'b1;
            rd_addr    = cur;
            state_next = S_R_NEXT;
          end else begin
            state_next = S_R_WRITE;
          end
        end
      end

      S_R_NEXT: begin
        if (next_bad) begin
          res_status_next = ST_CORRUPT;
          state_next      = S_RESP;
        end else begin
          if (next_merge) begin
            len_next         = len + LEN_W'(rd_size) + LEN_W'(next_gap);
            cur_next         = rd_ptr;
            merge_slack_next = merge_slack + DIFF_W'(next_gap);
          end
          state_next = S_R_WRITE;
        end
      end

      S_R_WRITE: begin
        wr_en           = 1'b1;
        wr_addr         = ofs;
        wr_data         = {len[SIZE_W-1:0], SIZE_W'(cur)};
        frag_next       = frag_sub;
        free_head_next  = head;
        res_status_next = ST_OK;
        state_next      = link_prev ? S_R_LINK : S_RESP;
      end

      S_R_LINK: begin
        wr_en      = 1'b1;
        wr_addr    = prev;
        wr_data    = {prev_size, SIZE_W'(ofs)};
        state_next = S_RESP;
      end

      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_offset_next = (res_status == ST_OK) ? res_offset : '0;
          out_status_next = res_status;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      cell_top   <= CS_W'(PAGE_BYTES);
      frag       <= '0;
      gap_floor  <= '0;
      max_frag   <= FRAG_W'(MAX_FRAG_RESET);
      out_valid  <= 1'b0;
      hops       <= '0;
      out_offset <= '0;
      out_status <= ST_OK;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      cell_top   <= cell_top_next;
      frag       <= frag_next;
      out_valid  <= out_valid_next;
      hops       <= hops_next;
      out_offset <= out_offset_next;
      out_status <= out_status_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_GAP_FLOOR:     gap_floor <= cfg.data[OFS_W-1:0];
          CFG_MAX_FRAGMENTS: max_frag  <= cfg.data[FRAG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    need        <= need_next;
    ofs         <= ofs_next;
    len         <= len_next;
    cur         <= cur_next;
    prev        <= prev_next;
    prev_size   <= prev_size_next;
    head        <= head_next;
    link_prev   <= link_prev_next;
    merge_slack <= merge_slack_next;
    res_offset  <= res_offset_next;
    res_status  <= res_status_next;
  end

  // cell_top only ever moves down from the page size
  a_cell_top_range: assert property (@(posedge clk) disable iff (rst)
    cell_top <= CS_W'(PAGE_BYTES))
    else $error("cell_top above page size");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("request transfer did not start work");

  a_hop_bound: assert property (@(posedge clk) disable iff (rst)
    hops <= HOP_W'(MAX_HOPS))
    else $error("list walk ran past hop limit");

  a_link_sorted: assert property (@(posedge clk) disable iff (rst)
    state == S_R_LINK |-> prev < ofs)
    else $error("release would link list out of order");

  a_header_nonzero: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> wr_addr != '0)
    else $error("header write to offset zero");

endmodule
